// ----- rtl/crcfc_pkg.sv -----
// ----------------------------------------------------------------------------
// CRC-16 frame checker package
// Shared types, register map, status codes and the nibble-wise CRC update.
// ----------------------------------------------------------------------------
package crcfc_pkg;

  // Register map: one word index per register.
  localparam logic REG_MAX_PAYLOAD = 1'b0;
  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd210;

  // Byte counter saturates here, beyond every meaningful position.
  localparam logic [8:0] POS_LIMIT = 9'd511;

  // Frame status reported with each result item.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_CRC_ERR    = 2'd1,
    ST_SHORT      = 2'd2,
    ST_OVER_LIMIT = 2'd3
  } status_t;

  // Reflected CRC-16 (0x8408) nibble table.
  localparam logic [15:0] NIB_TABLE [16] = '{
    16'h0000, 16'h1081, 16'h2102, 16'h3183, 16'h4204, 16'h5285, 16'h6306, 16'h7387,
    16'h8408, 16'h9489, 16'ha50a, 16'hb58b, 16'hc60c, 16'hd68d, 16'he70e, 16'hf78f
  };

  // One byte update: low nibble first, then high nibble.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c1;
    logic [15:0] c2;
    c1 = {4'h0, crc[15:4]} ^ NIB_TABLE[crc[3:0] ^ b[3:0]];
    c2 = {4'h0, c1[15:4]} ^ NIB_TABLE[c1[3:0] ^ b[7:4]];
    return c2;
  endfunction

endpackage

// ----- rtl/crcfc_if.sv -----
// ----------------------------------------------------------------------------
// CRC-16 frame checker channels
// Valid/ready channels for packet bytes in and frame reports out.
// ----------------------------------------------------------------------------

// Input channel: one packet byte per item.
interface crcfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

// Result channel: one frame report per item.
interface crcfc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  channel_id;
  logic [7:0]  payload_length;
  logic [15:0] received_crc;
  logic [15:0] computed_crc;
  logic [1:0]  status;

  modport source (output valid, output channel_id, output payload_length,
                  output received_crc, output computed_crc, output status, input ready);
  modport sink   (input valid, input channel_id, input payload_length,
                  input received_crc, input computed_crc, input status, output ready);
endinterface

// ----- rtl/crc16_frame_checker_unit.sv -----
// ----------------------------------------------------------------------------
// CRC-16 frame checker
// Checks decoded packets (channel, length, payload, CRC low byte first).
// ----------------------------------------------------------------------------
// The unit takes one packet byte per cycle on in_ch and gives one report on
// out_ch for each byte flagged as the end of a packet: the channel, the length,
// the received and computed reflected CRC-16 (0x8408, initial value zero) and a
// status of ok, CRC mismatch, short packet or length over the limit. A byte is
// held in an input register, where the nibble-table CRC update and header and
// trailer capture run, and the report register is loaded from there when the
// held end byte moves on, which waits while an earlier report is not yet taken.
// Bytes are taken every cycle; the input stalls only when an end byte meets
// a report that the sink has not yet taken. The length limit is written at
// word 0 of the APB port.
// ----------------------------------------------------------------------------
module crc16_frame_checker_unit
  import crcfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  crcfc_in_if.sink      in_ch,
  crcfc_out_if.source   out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [7:0] max_payload;

  // Configuration registers.
  crcfc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  // Frame datapath.
  crcfc_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_payload (max_payload),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

endmodule

// ----- rtl/crcfc_cfg.sv -----
// ----------------------------------------------------------------------------
// CRC-16 frame checker configuration registers
// APB-style register file holding the payload length limit.
// ----------------------------------------------------------------------------
module crcfc_cfg
  import crcfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  max_payload
);

  logic [7:0] max_payload_r;
  logic       wr_en;
  logic       reg_idx;

  // Word index of the access; writes complete in the access phase.
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RESET;
    end else if (wr_en && (reg_idx == REG_MAX_PAYLOAD)) begin
      max_payload_r <= pwdata[7:0];
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_idx)
      REG_MAX_PAYLOAD: prdata = {24'h0, max_payload_r};
      default:         prdata = 32'h0;
    endcase
  end

  assign max_payload = max_payload_r;

endmodule

// ----- rtl/crcfc_frame.sv -----
// ----------------------------------------------------------------------------
// CRC-16 frame checker datapath
// Input register, frame state update and registered frame report.
// ----------------------------------------------------------------------------
module crcfc_frame
  import crcfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        max_payload,
  crcfc_in_if.sink          in_ch,
  crcfc_out_if.source       out_ch
);

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eop_r;

  // Frame state.
  logic [15:0] crc_r,     crc_nxt;
  logic [8:0]  pos_r,     pos_nxt;
  logic [7:0]  chan_r,    chan_nxt;
  logic [7:0]  len_r,     len_nxt;
  logic [15:0] trailer_r, trailer_nxt;

  // Result register.
  logic        out_valid_r;
  logic [7:0]  res_chan_r;
  logic [7:0]  res_len_r;
  logic [15:0] res_rx_crc_r;
  logic [15:0] res_crc_r;
  status_t     res_status_r;
  status_t     status_nxt;

  logic        proc_ok;
  logic        fire;
  logic        in_fire;
  logic        out_fire;
  logic [9:0]  len_ext;
  logic [9:0]  pos_ext;
  logic [9:0]  count;

  // The held byte moves on unless it ends a frame and the report slot is busy.
  assign out_fire    = out_valid_r && out_ch.ready;
  assign proc_ok     = !s1_eop_r || !out_valid_r || out_ch.ready;
  assign fire        = s1_valid_r && proc_ok;
  assign in_ch.ready = !s1_valid_r || proc_ok;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Header capture, CRC update and trailer capture for the held byte.
  always_comb begin
    chan_nxt    = (pos_r == 9'd0) ? s1_byte_r : chan_r;
    len_nxt     = (pos_r == 9'd1) ? s1_byte_r : len_r;
    crc_nxt     = crc_r;
    trailer_nxt = trailer_r;
    len_ext     = {2'b00, len_nxt};
    pos_ext     = {1'b0, pos_r};
    if (pos_ext < len_ext + 10'd2) begin
      crc_nxt = crc_byte(crc_r, s1_byte_r);
    end else if (pos_ext == len_ext + 10'd2) begin
      trailer_nxt = {trailer_r[15:8], s1_byte_r};
    end else if (pos_ext == len_ext + 10'd3) begin
      trailer_nxt = {s1_byte_r, trailer_r[7:0]};
    end
    pos_nxt = (pos_r < POS_LIMIT) ? pos_r + 9'd1 : pos_r;
    count   = pos_ext + 10'd1;

    // Status priority: too short for a header, over the limit, short, CRC.
    if (count < 10'd2) begin
      status_nxt = ST_SHORT;
    end else if (len_nxt > max_payload) begin
      status_nxt = ST_OVER_LIMIT;
    end else if (count < len_ext + 10'd4) begin
      status_nxt = ST_SHORT;
    end else if (trailer_nxt != crc_nxt) begin
      status_nxt = ST_CRC_ERR;
    end else begin
      status_nxt = ST_OK;
    end
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.data_byte;
      s1_eop_r  <= in_ch.end_of_packet;
    end
  end

  // Frame state: updated per byte, cleared after the end byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= 16'h0;
      pos_r     <= 9'd0;
      chan_r    <= 8'h0;
      len_r     <= 8'h0;
      trailer_r <= 16'h0;
    end else if (fire) begin
      if (s1_eop_r) begin
        crc_r     <= 16'h0;
        pos_r     <= 9'd0;
        chan_r    <= 8'h0;
        len_r     <= 8'h0;
        trailer_r <= 16'h0;
      end else begin
        crc_r     <= crc_nxt;
        pos_r     <= pos_nxt;
        chan_r    <= chan_nxt;
        len_r     <= len_nxt;
        trailer_r <= trailer_nxt;
      end
    end
  end

  // Report register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && s1_eop_r) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_eop_r) begin
      res_chan_r   <= chan_nxt;
      res_len_r    <= len_nxt;
      res_rx_crc_r <= trailer_nxt;
      res_crc_r    <= crc_nxt;
      res_status_r <= status_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.channel_id     = res_chan_r;
  assign out_ch.payload_length = res_len_r;
  assign out_ch.received_crc   = res_rx_crc_r;
  assign out_ch.computed_crc   = res_crc_r;
  assign out_ch.status         = res_status_r;

endmodule

// ----- test/crcfc_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame checker test package
// Register address and a bit-serial reflected CRC-16 shared by the
// testbench stimulus and the frame report predictor.
// ----------------------------------------------------------------------------
package crcfc_tb_pkg;

  import crcfc_pkg::*;

  // Byte address of the length limit register on the APB port.
  localparam logic [2:0] LIMIT_REG_ADDR = {REG_MAX_PAYLOAD, 2'b00};

  // Reflected polynomial of CRC-16/KERMIT.
  localparam logic [15:0] CRC_POLY_REFLECTED = 16'h8408;

  // Bit-serial update, LSB first, for one packet byte.
  function automatic logic [15:0] kermit_crc_byte(input logic [15:0] crc,
                                                  input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- test/crcfc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame checker report predictor
// Watches the byte channel, the report channel and the APB port, predicts
// one frame report per end-of-packet byte and compares each delivered
// report field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module crcfc_checker
  import crcfc_pkg::*;
  import crcfc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  crcfc_in_if         in_ch,
  crcfc_out_if        out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned fail_count,
  output int unsigned reports_pending,
  output int unsigned reports_seen
);

  typedef struct packed {
    logic [7:0]  channel_id;
    logic [7:0]  payload_length;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
    status_t     status;
  } frame_report_t;

  // Predicted frame state and the length limit in force.
  logic [15:0] crc_acc;
  logic [8:0]  pos_cnt;
  logic [7:0]  hdr_chan;
  logic [7:0]  hdr_len;
  logic [15:0] rx_crc;
  logic [7:0]  limit_len;

  frame_report_t expected_reports[$];
  frame_report_t want;
  int unsigned   err_total;
  int unsigned   seen_total;

  initial begin
    err_total  = 0;
    seen_total = 0;
  end

  task automatic clear_frame();
    crc_acc  = '0;
    pos_cnt  = '0;
    hdr_chan = '0;
    hdr_len  = '0;
    rx_crc   = '0;
  endtask

  // Advance the frame state by one byte; an end byte yields a report.
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int            pos;
    status_t       st;
    frame_report_t rep;
    pos = int'(pos_cnt);
    if (pos == 0) begin
      hdr_chan = b;
    end else if (pos == 1) begin
      hdr_len = b;
    end
    if (pos < int'(hdr_len) + 2) begin
      crc_acc = kermit_crc_byte(crc_acc, b);
    end else if (pos == int'(hdr_len) + 2) begin
      rx_crc[7:0] = b;
    end else if (pos == int'(hdr_len) + 3) begin
      rx_crc[15:8] = b;
    end
    if (pos_cnt < POS_LIMIT) begin
      pos_cnt = pos_cnt + 9'd1;
    end
    if (last) begin
      // A lone byte is short; otherwise the limit wins over shortness.
      if (pos + 1 < 2) begin
        st = ST_SHORT;
      end else if (hdr_len > limit_len) begin
        st = ST_OVER_LIMIT;
      end else if (pos + 1 < int'(hdr_len) + 4) begin
        st = ST_SHORT;
      end else if (rx_crc != crc_acc) begin
        st = ST_CRC_ERR;
      end else begin
        st = ST_OK;
      end
      rep = '{hdr_chan, hdr_len, rx_crc, crc_acc, st};
      expected_reports.push_back(rep);
      clear_frame();
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
      err_total++;
    end
  endtask

  // Track configuration, predict on accepted bytes, compare accepted reports.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      limit_len = MAX_PAYLOAD_RESET;
      expected_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == LIMIT_REG_ADDR) begin
        limit_len = pwdata[7:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        absorb_byte(in_ch.data_byte, in_ch.end_of_packet);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_total++;
        if (expected_reports.size() == 0) begin
          $error("frame report arrived with none expected");
          err_total++;
        end else begin
          want = expected_reports.pop_front();
          check_field("channel_id", 16'(want.channel_id), 16'(out_ch.channel_id));
          check_field("payload_length", 16'(want.payload_length),
                      16'(out_ch.payload_length));
          check_field("received_crc", want.received_crc, out_ch.received_crc);
          check_field("computed_crc", want.computed_crc, out_ch.computed_crc);
          check_field("status", 16'(want.status), 16'(out_ch.status));
        end
      end
    end
    fail_count      <= err_total;
    reports_pending <= expected_reports.size();
    reports_seen    <= seen_total;
  end

endmodule

// ----- test/crc16_frame_checker_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame checker testbench
// Sends directed and random packets (good, corrupted, short, padded, over
// the length limit, saturating) under several length limits, with random
// idling on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module crc16_frame_checker_unit_tb;

  import crcfc_pkg::*;
  import crcfc_tb_pkg::*;

  localparam int RANDOM_BYTES    = 840;
  localparam int NUM_PHASES      = 7;
  localparam int PRESSURE_HOLD   = 400;
  localparam int SETTLE_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int LONG_FRAME_PAD  = 300;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crcfc_in_if  in_ch();
  crcfc_out_if out_ch();

  int unsigned fail_count;
  int unsigned reports_pending;
  int unsigned reports_seen;

  bit          hold_req;
  bit          send_burst;
  bit          recv_burst;
  logic [7:0]  cur_limit;
  logic [7:0]  frame_buf[$];
  int unsigned bytes_sent;
  int unsigned packets_sent;
  int unsigned limits_used;
  int unsigned idle_cycles;

  crc16_frame_checker_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  crcfc_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .reports_pending (reports_pending),
    .reports_seen    (reports_seen)
  );

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Report receiver: random stalls, bursts of no stalls, one long hold-off.
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    recv_burst = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
      end else begin
        stall = recv_burst ? 0 : $urandom_range(13, 0);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if ($urandom_range(15, 0) == 0) recv_burst = !recv_burst;
    end
  end

  // Offer one byte after a random gap and wait for it to be taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(13, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_packet <= last;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
    packets_sent++;
  endtask

  // Append the CRC of the bytes so far, low byte first, optionally corrupted.
  task automatic seal_frame(input bit corrupt);
    logic [15:0] crc;
    crc = '0;
    foreach (frame_buf[i]) crc = kermit_crc_byte(crc, frame_buf[i]);
    if (corrupt) crc ^= 16'(1) << $urandom_range(15, 0);
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
  endtask

  task automatic build_frame(input logic [7:0] len, input bit corrupt);
    frame_buf.delete();
    frame_buf.push_back(8'($urandom_range(255, 0)));
    frame_buf.push_back(len);
    repeat (len) frame_buf.push_back(8'($urandom_range(255, 0)));
    seal_frame(corrupt);
  endtask

  // Mostly small lengths, some near the limit, a few anywhere.
  function automatic logic [7:0] pick_length();
    int r;
    int v;
    r = int'($urandom_range(15, 0));
    if (r == 0) return 8'($urandom_range(255, 0));
    if (r <= 2) begin
      v = int'(cur_limit) + int'($urandom_range(2, 0)) - 1;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
    end
    return 8'($urandom_range(12, 0));
  endfunction

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop offering bytes and wait until every report has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(LIMIT_REG_ADDR, {24'($urandom()), value});
    cur_limit = value;
    limits_used++;
  endtask

  // Random packets of every kind until the byte goal of the phase is met.
  task automatic run_random_phase(input int unsigned goal);
    int unsigned start;
    int unsigned kind;
    int unsigned cut;
    logic [7:0]  len;
    start = bytes_sent;
    while (bytes_sent - start < goal) begin
      send_burst = ($urandom_range(5, 0) == 0);
      kind = $urandom_range(15, 0);
      if (kind <= 8) begin
        build_frame(pick_length(), 1'b0);
      end else if (kind <= 10) begin
        build_frame(pick_length(), 1'b1);
      end else if (kind == 11) begin
        // Short packet: cut the tail, keep at least one byte.
        build_frame(pick_length(), 1'b0);
        cut = $urandom_range(frame_buf.size() - 1, 1);
        repeat (cut) void'(frame_buf.pop_back());
      end else if (kind == 12) begin
        // Padding after the trailer.
        build_frame(pick_length(), 1'($urandom_range(1, 0)));
        repeat ($urandom_range(5, 1)) frame_buf.push_back(8'($urandom_range(255, 0)));
      end else if (kind == 13) begin
        // Length over the limit (any length under a limit of 255), sometimes also short.
        if (cur_limit < 8'd255) begin
          len = 8'($urandom_range(int'(cur_limit) + 8 > 255 ? 255 : int'(cur_limit) + 8,
                                  int'(cur_limit) + 1));
        end else begin
          len = pick_length();
        end
        build_frame(len, 1'b0);
        if ($urandom_range(1, 0) == 1) begin
          cut = $urandom_range(frame_buf.size() - 1, 1);
          repeat (cut) void'(frame_buf.pop_back());
        end
      end else begin
        // Noise bytes.
        frame_buf.delete();
        repeat ($urandom_range(6, 1)) frame_buf.push_back(8'($urandom_range(255, 0)));
      end
      send_frame();
    end
  endtask

  // Stimulus and verdict.
  initial begin
    logic [7:0] phase_limits [NUM_PHASES];
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.end_of_packet <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    hold_req     = 1'b0;
    send_burst   = 1'b0;
    cur_limit    = MAX_PAYLOAD_RESET;
    bytes_sent   = 0;
    packets_sent = 0;
    limits_used  = 1;
    phase_limits = '{8'd0, 8'd255, 8'd7, 8'($urandom_range(255, 0)), 8'd210, 8'd1,
                     8'($urandom_range(255, 0))};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed packets under the reset limit.
    // A single byte is a short packet.
    frame_buf = '{8'hff};
    send_frame();
    // Two bytes with a length over the limit report the limit, not shortness.
    frame_buf = '{8'h00, 8'hff};
    send_frame();
    // Empty payload with a good CRC.
    frame_buf = '{8'h00, 8'h00};
    seal_frame(1'b0);
    send_frame();
    // All-ones channel and payload byte with a good CRC.
    frame_buf = '{8'hff, 8'h01, 8'hff};
    seal_frame(1'b0);
    send_frame();
    // Corrupted CRC.
    frame_buf = '{8'h5a, 8'h01, 8'ha5};
    seal_frame(1'b1);
    send_frame();
    // Trailer never arrives, so the received CRC reads as zero.
    frame_buf = '{8'h01, 8'h03, 8'h11, 8'h22};
    send_frame();
    // A byte after the trailer is ignored.
    frame_buf = '{8'h02, 8'h00};
    seal_frame(1'b0);
    frame_buf.push_back(8'h7e);
    send_frame();

    // Random phases, one length limit each.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_limit(phase_limits[ph]);
      if (ph == 1) begin
        // Longest frame plus padding so the byte counter saturates.
        build_frame(8'd255, 1'b0);
        repeat (LONG_FRAME_PAD) frame_buf.push_back(8'($urandom_range(255, 0)));
        send_frame();
      end
      if (ph == 2) hold_req = 1'b1;
      run_random_phase(RANDOM_BYTES / NUM_PHASES);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d packet bytes in %0d packets under %0d length limits,",
             bytes_sent, packets_sent, limits_used);
    $display("with idling, one long receiver hold-off and a saturating frame; %0d reports.",
             reports_seen);
    if (fail_count == 0 && reports_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/crcfc_pkg.sv
rtl/crcfc_if.sv
rtl/crcfc_cfg.sv
rtl/crcfc_frame.sv
rtl/crc16_frame_checker_unit.sv
test/crcfc_tb_pkg.sv
test/crcfc_checker.sv
test/crc16_frame_checker_unit_tb.sv
